@@ hw/rtl/apq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_pkg: shared types and constants for the array priority queue
// Field widths, command and status codes, controller/datapath interface.
// ----------------------------------------------------------------------------
package apq_pkg;

  localparam int APQ_DEPTH = 16;
  localparam int PRIO_W    = 16;
  localparam int DATA_W    = 32;
  localparam int OCC_W     = 5;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_code_t;

  // controller -> datapath
  typedef struct packed {
    logic         capture;
    logic         ins_write;
    logic         set_res;
    status_code_t res_status;
    logic         res_take;
    logic         scan_start;
    logic         scan_step;
    logic         shift_init;
    logic         shift_step;
    logic         count_dec;
    logic         out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic req_remove;
    logic empty;
    logic full;
    logic scan_last;
    logic shift_done;
  } dp_stat_t;

endpackage

@@ hw/rtl/apq_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_dpath: entry store and scan/shift datapath
// Holds the entry memory, fill count, scan best tracking and result register.
// ----------------------------------------------------------------------------
module apq_dpath #(
  parameter int DEPTH = apq_pkg::APQ_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  apq_pkg::dp_cmd_t                  cmd,
  output apq_pkg::dp_stat_t                 stat,
  input  logic                              req_cmd,
  input  logic [apq_pkg::PRIO_W-1:0]        req_prio,
  input  logic signed [apq_pkg::DATA_W-1:0] req_payload,
  output apq_pkg::status_code_t             out_status,
  output logic [apq_pkg::PRIO_W-1:0]        out_prio,
  output logic signed [apq_pkg::DATA_W-1:0] out_payload,
  output logic [apq_pkg::OCC_W-1:0]         out_occ
);
  import apq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [PRIO_W-1:0]        mem_prio [DEPTH];
  logic signed [DATA_W-1:0] mem_data [DEPTH];

  logic                     r_cmd;
  logic [PRIO_W-1:0]        r_prio;
  logic signed [DATA_W-1:0] r_payload;

  logic [CW-1:0]            count;
  logic [CW-1:0]            idx;
  logic [CW-1:0]            idx_inc;

  logic [PRIO_W-1:0]        rd_prio;
  logic signed [DATA_W-1:0] rd_data;
  logic [AW-1:0]            cmp_idx;
  logic                     cmp_vld;
  logic                     cmp_first;
  logic [AW-1:0]            wb_addr;
  logic                     wb_vld;

  logic [PRIO_W-1:0]        best_prio;
  logic signed [DATA_W-1:0] best_data;
  logic [AW-1:0]            best_idx;

  status_code_t             res_status;
  logic                     res_take;

  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  logic [PRIO_W-1:0]        wr_prio;
  logic signed [DATA_W-1:0] wr_data;

  assign idx_inc = idx + CW'(1);

  always_comb begin
    rd_en   = cmd.scan_step | cmd.shift_step;
    rd_addr = cmd.shift_step ? idx_inc[AW-1:0] : idx[AW-1:0];
    wr_en   = cmd.ins_write | wb_vld;
    wr_addr = cmd.ins_write ? count[AW-1:0] : wb_addr;
    wr_prio = cmd.ins_write ? r_prio : rd_prio;
    wr_data = cmd.ins_write ? r_payload : rd_data;
  end

  always_comb begin
    stat.req_remove = (r_cmd == CMD_REMOVE);
    stat.empty      = (count == '0);
    stat.full       = (count == CW'(DEPTH));
    stat.scan_last  = (idx == count - CW'(1));
    stat.shift_done = (idx_inc == count);
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_prio[wr_addr] <= wr_prio;
      mem_data[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_prio <= mem_prio[rd_addr];
      rd_data <= mem_data[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      cmp_vld <= 1'b0;
      wb_vld  <= 1'b0;
    end else begin
      cmp_vld <= cmd.scan_step;
      wb_vld  <= cmd.shift_step;
      if (cmd.ins_write) begin
        count <= count + CW'(1);
      end else if (cmd.count_dec) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_cmd     <= req_cmd;
      r_prio    <= req_prio;
      r_payload <= req_payload;
    end
    if (cmd.set_res) begin
      res_status <= cmd.res_status;
      res_take   <= cmd.res_take;
    end
    if (cmd.scan_start) begin
      idx <= '0;
    end else if (cmd.shift_init) begin
      idx <= CW'(best_idx);
    end else if (rd_en) begin
      idx <= idx_inc;
    end
    if (cmd.scan_step) begin
      cmp_idx   <= idx[AW-1:0];
      cmp_first <= (idx == '0);
    end
    if (cmd.shift_step) begin
      wb_addr <= idx[AW-1:0];
    end
    // strict compare keeps the earliest entry on ties
    if (cmp_vld && (cmp_first || rd_prio > best_prio)) begin
      best_prio <= rd_prio;
      best_data <= rd_data;
      best_idx  <= cmp_idx;
    end
    if (cmd.out_load) begin
      out_status  <= res_status;
      out_prio    <= res_take ? best_prio : '0;
      out_payload <= res_take ? best_data : '0;
      out_occ     <= OCC_W'(count);
    end
  end

endmodule

@@ hw/rtl/apq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apq_ctrl: command sequencer
// Accepts one transaction, steps the datapath through insert or scan/shift,
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module apq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  apq_pkg::dp_stat_t stat,
  output apq_pkg::dp_cmd_t  cmd
);
  import apq_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_EXEC       = 7'b0000010,
    S_SCAN       = 7'b0000100,
    S_SCAN_END   = 7'b0001000,
    S_SHIFT_INIT = 7'b0010000,
    S_SHIFT      = 7'b0100000,
    S_DONE       = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.res_status = ST_OK;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_res = 1'b1;
        if (!stat.req_remove) begin
          if (stat.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.ins_write = 1'b1;
          end
          state_next = S_DONE;
        end else if (stat.empty) begin
          cmd.res_status = ST_EMPTY;
          state_next     = S_DONE;
        end else begin
          cmd.res_take   = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_last) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // last compare lands this cycle
        state_next = S_SHIFT_INIT;
      end
      S_SHIFT_INIT: begin
        cmd.shift_init = 1'b1;
        state_next     = S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          cmd.count_dec = 1'b1;
          state_next    = S_DONE;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/array_priority_queue.sv @@
`timescale 1ns / 1ps
// Insert, full or empty result: captured, executed, then loaded into the output
// register once free. Remove scans all n stored entries, then shifts down the k after the winner;
// the scan and the shift each use the single read port of the entry memory.
// Throughput: one transaction at a time, the next one accepted in the cycle
// after the previous result enters the output register.
// Reset (rst, synchronous): queue empty, no result pending; entry memory kept.
// ----------------------------------------------------------------------------
// array_priority_queue: unsorted array priority queue, extract max
// Appends entries in arrival order; remove returns the earliest highest one.
// ----------------------------------------------------------------------------
module array_priority_queue #(
  parameter int DEPTH = apq_pkg::APQ_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // [15:0] priority_req, [47:16] payload
  input  logic [0:0]  s_tuser,  // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,  // [15:0] out_priority, [47:16] out_payload,
                                // [52:48] occupancy, [55:53] zero
  output logic [1:0]  m_tuser   // [1:0] status
);
  import apq_pkg::*;

  dp_cmd_t                  cmd;
  dp_stat_t                 stat;
  status_code_t             out_status;
  logic [PRIO_W-1:0]        out_prio;
  logic signed [DATA_W-1:0] out_payload;
  logic [OCC_W-1:0]         out_occ;

  apq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  apq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .req_cmd     (s_tuser[0]),
    .req_prio    (s_tdata[15:0]),
    .req_payload (s_tdata[47:16]),
    .out_status  (out_status),
    .out_prio    (out_prio),
    .out_payload (out_payload),
    .out_occ     (out_occ)
  );

  assign m_tdata = {3'b000, out_occ, out_payload, out_prio};
  assign m_tuser = out_status;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for array_priority_queue
// Drives insert/remove transactions with bursty input and a stalling output,
// predicts every result (status, removed entry, occupancy) from a local
// copy of the store, and compares each delivered result in order.
// ----------------------------------------------------------------------------
module testbench;
  import apq_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int HOLD_AT      = 140;   // random item after which the sink holds off
  localparam int DRAIN_AT     = 300;   // random item after which the source drains
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 60;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    status_code_t       status;
    logic [PRIO_W-1:0]  prio;
    logic [DATA_W-1:0]  data;
    logic [OCC_W-1:0]   occ;
  } pq_result_t;

  // Local model of the queue plus the list of results still owed by the block
  class pq_scoreboard;
    logic [PRIO_W-1:0] held_prio [APQ_DEPTH];
    logic [DATA_W-1:0] held_data [APQ_DEPTH];
    int                held_count;
    pq_result_t        owed_q [$];
    int                error_count;

    function new();
      held_count  = 0;
      error_count = 0;
    endfunction

    function void note_command(cmd_code_t cmd, logic [PRIO_W-1:0] prio,
                               logic [DATA_W-1:0] data);
      pq_result_t r;
      int         best;
      r.status = ST_OK;
      r.prio   = '0;
      r.data   = '0;
      if (cmd == CMD_INSERT) begin
        if (held_count >= APQ_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          held_prio[held_count] = prio;
          held_data[held_count] = data;
          held_count++;
        end
      end else if (held_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        // strict compare: earliest entry wins a tie
        best = 0;
        for (int i = 1; i < held_count; i++)
          if (held_prio[i] > held_prio[best]) best = i;
        r.prio = held_prio[best];
        r.data = held_data[best];
        for (int i = best; i + 1 < held_count; i++) begin
          held_prio[i] = held_prio[i + 1];
          held_data[i] = held_data[i + 1];
        end
        held_count--;
      end
      r.occ = OCC_W'(held_count);
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got 0x%0h expected 0x%0h", what, got, want);
      error_count++;
    endtask

    task check_result(logic [1:0] status, logic [55:0] tdata);
      pq_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result with nothing pending", {30'd0, status}, 32'd0);
      end else begin
        want = owed_q.pop_front();
        if (status !== want.status)
          report_mismatch("status", {30'd0, status}, {30'd0, want.status});
        if (tdata[15:0] !== want.prio)
          report_mismatch("out_priority", {16'd0, tdata[15:0]}, {16'd0, want.prio});
        if (tdata[47:16] !== want.data)
          report_mismatch("out_payload", tdata[47:16], want.data);
        if (tdata[52:48] !== want.occ)
          report_mismatch("occupancy", {27'd0, tdata[52:48]}, {27'd0, want.occ});
      end
    endtask

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;   // [15:0] priority_req, [47:16] payload
  logic [0:0]  s_tuser  = '0;   // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;         // [15:0] out_priority, [47:16] out_payload,
                                // [52:48] occupancy, [55:53] zero
  logic [1:0]  m_tuser;         // [1:0] status

  bit           long_hold_req = 1'b0;
  int           cycle_count   = 0;
  pq_scoreboard sb            = new();

  array_priority_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
  end

  // Sink: random ready/stall runs, one long hold-off on request
  initial begin
    int run_len;
    int stall_len;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        run_len   = $urandom_range(1, 20);
        stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        m_tready <= 1'b1;
        repeat (run_len) @(negedge clk);
        if (stall_len > 0) begin
          m_tready <= 1'b0;
          repeat (stall_len) @(negedge clk);
        end
      end
    end
  end

  // Present one transaction and hold it until the block takes it.
  // tvalid is left high so a burst continues without a drop.
  task automatic send_command(cmd_code_t cmd, logic [PRIO_W-1:0] prio,
                              logic [DATA_W-1:0] data);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {data, prio};
    do @(posedge clk); while (!s_tready);
    sb.note_command(cmd, prio, data);
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_results();
    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    int                sent;
    int                burst_left;
    int                gap;
    int                seg_len;
    int                insert_pct;
    int                pick;
    cmd_code_t         cmd;
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: remove on empty, fill to full with ties and extremes,
    // insert on full, then removes that pick tied maxima in arrival order
    send_command(CMD_REMOVE, 16'hFFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < APQ_DEPTH; i++) begin
      case (i % 4)
        0:       prio = 16'hFFFF;
        1:       prio = 16'h0000;
        default: prio = PRIO_W'(i * 1237);
      endcase
      if (i == 0)      data = 32'h8000_0000;
      else if (i == 1) data = 32'h7FFF_FFFF;
      else if (i == 2) data = 32'h0000_0000;
      else             data = {16'(i), ~16'(i)};
      send_command(CMD_INSERT, prio, data);
    end
    send_command(CMD_INSERT, 16'h1234, 32'hDEAD_BEEF);
    repeat (6) send_command(CMD_REMOVE, 16'h0000, 32'h0000_0000);
    wait_for_results();

    // Random: segments biased toward filling, draining or mixing
    sent       = 0;
    burst_left = $urandom_range(1, 12);
    while (sent < RANDOM_ITEMS) begin
      seg_len = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      for (int k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        cmd  = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
        pick = $urandom_range(0, 19);
        if (pick < 6)       prio = PRIO_W'($urandom_range(0, 3));  // many ties
        else if (pick == 6) prio = 16'h0000;
        else if (pick == 7) prio = 16'hFFFF;
        else                prio = PRIO_W'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0)      data = 32'h8000_0000;
        else if (pick == 1) data = 32'h7FFF_FFFF;
        else                data = $urandom;
        send_command(cmd, prio, data);
        sent++;
        if (sent == HOLD_AT) long_hold_req = 1'b1;
        if (sent == DRAIN_AT) wait_for_results();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) pause_sender(gap);
        end
      end
    end

    wait_for_results();
    if (sb.pending() != 0)
      sb.report_mismatch("results never delivered", sb.pending(), 32'd0);
    if (sb.error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
